// ===== hw/rtl/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the sorted array list.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int SAL_DEPTH     = 8;
    localparam int SAL_VAL_W     = 32;
    localparam int SAL_POS_W     = 3;
    localparam int SAL_COUNT_W   = 4;

    typedef enum logic [1:0] {
        CMD_INSERT       = 2'd0,
        CMD_READ         = 2'd1,
        CMD_REMOVE_AT    = 2'd2,
        CMD_REMOVE_VALUE = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic                        ins;
        logic                        del;
        logic                        by_value;
        logic signed [SAL_VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/sal_cell.sv =====
// ----------------------------------------------------------------------------
// sal_cell
// One slot of the list: holds one entry, compares it with the broadcast
// value; on insert takes the left entry or the value, on remove the right.
// ----------------------------------------------------------------------------
module sal_cell (
    input  logic                                 i_clk,
    input  sal_pkg::t_cell_ctrl                  i_ctrl,
    input  logic                                 i_valid,
    input  logic                                 i_sel,
    input  logic signed [sal_pkg::SAL_VAL_W-1:0] i_left_entry,
    input  logic signed [sal_pkg::SAL_VAL_W-1:0] i_right_entry,
    input  logic                                 i_left_gt,
    input  logic                                 i_left_hit,
    output logic signed [sal_pkg::SAL_VAL_W-1:0] o_entry,
    output logic                                 o_gt,
    output logic                                 o_hit
);
    import sal_pkg::*;

    logic signed [SAL_VAL_W-1:0] r_entry;
    logic signed [SAL_VAL_W-1:0] n_entry;

    // empty slots compare as greater than any value
    assign o_gt  = !i_valid || (i_ctrl.value < r_entry);
    assign o_hit = i_ctrl.by_value ? (i_left_hit || (i_valid && (r_entry == i_ctrl.value)))
                                   : i_sel;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (i_left_gt) begin
                n_entry = i_left_entry;
            end else if (o_gt) begin
                n_entry = i_ctrl.value;
            end
        end else if (i_ctrl.del && o_hit) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/sorted_array_list.sv =====
// ----------------------------------------------------------------------------
// sorted_array_list
// Ascending list of signed values held in a row of cells, with a count.
//
//   channel   signals                                      direction
//   command   start, busy, i_command, i_value, i_position  in
//   result    o_valid, o_read_value, o_status, o_count     out
//
// A command is taken on any cycle start is high and busy is low; its result
// appears on the following cycle with o_valid high for one cycle.
// One command per cycle while busy is low: every cell compares and shifts in the same cycle.
// busy is high only while i_rst_n is low. Reset clears the count; entries
// are not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
module sorted_array_list #(
    parameter int DEPTH = sal_pkg::SAL_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_command,
    input  logic signed [sal_pkg::SAL_VAL_W-1:0] i_value,
    input  logic [sal_pkg::SAL_POS_W-1:0]        i_position,
    output logic                                 o_valid,
    output logic signed [sal_pkg::SAL_VAL_W-1:0] o_read_value,
    output logic [1:0]                           o_status,
    output logic [sal_pkg::SAL_COUNT_W-1:0]      o_count
);
    import sal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > SAL_POS_W) ? CW : SAL_POS_W;

    logic                        accept;
    t_command                    cmd;
    logic [PW-1:0]               pos_w;
    logic [PW-1:0]               count_w;
    logic                        pos_ok;
    logic                        full;
    t_cell_ctrl                  ctrl;

    logic signed [SAL_VAL_W-1:0] w_entry [DEPTH];
    logic                        w_gt    [DEPTH];
    logic                        w_hit   [DEPTH];
    logic signed [SAL_VAL_W-1:0] rd_sel;

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_valid;
    logic signed [SAL_VAL_W-1:0] r_read_value;
    logic signed [SAL_VAL_W-1:0] n_read_value;
    t_status                     r_status;
    t_status                     n_status;

    assign busy    = ~i_rst_n;
    assign accept  = start && !busy;
    assign cmd     = t_command'(i_command);
    assign pos_w   = PW'(i_position);
    assign count_w = PW'(r_count);
    assign pos_ok  = pos_w < count_w;
    assign full    = r_count >= CW'(DEPTH);

    always_comb begin
        ctrl.ins      = accept && (cmd == CMD_INSERT) && !full;
        ctrl.del      = accept && (((cmd == CMD_REMOVE_AT) && pos_ok) ||
                                   (cmd == CMD_REMOVE_VALUE));
        ctrl.by_value = (cmd == CMD_REMOVE_VALUE);
        ctrl.value    = i_value;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [SAL_VAL_W-1:0] left_entry;
        logic signed [SAL_VAL_W-1:0] right_entry;
        logic                        left_gt;
        logic                        left_hit;

        if (g == 0) begin : g_first
            assign left_entry = w_entry[g];
            assign left_gt    = 1'b0;
            assign left_hit   = 1'b0;
        end else begin : g_mid
            assign left_entry = w_entry[g-1];
            assign left_gt    = w_gt[g-1];
            assign left_hit   = w_hit[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_entry = w_entry[g];
        end else begin : g_inner
            assign right_entry = w_entry[g+1];
        end

        sal_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_valid      (CW'(g) < r_count),
            .i_sel        (pos_w <= PW'(g)),
            .i_left_entry (left_entry),
            .i_right_entry(right_entry),
            .i_left_gt    (left_gt),
            .i_left_hit   (left_hit),
            .o_entry      (w_entry[g]),
            .o_gt         (w_gt[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pos_w == PW'(i)) begin
                rd_sel = rd_sel | w_entry[i];
            end
        end
    end

    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_status     = ST_OK;
        unique case (cmd)
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_READ: begin
                if (pos_ok) begin
                    n_read_value = rd_sel;
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            CMD_REMOVE_AT: begin
                if (pos_ok) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            CMD_REMOVE_VALUE: begin
                if (w_hit[DEPTH-1]) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = SAL_COUNT_W'(r_count);

endmodule

// ===== hw/rtl/sal_checker.sv =====
// ----------------------------------------------------------------------------
// sal_checker
// Port-level checks on the sorted array list, bound to the top level.
// ----------------------------------------------------------------------------
module sal_checker #(
    parameter int DEPTH = sal_pkg::SAL_DEPTH
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [1:0]                           i_command,
    input logic                                 o_valid,
    input logic signed [sal_pkg::SAL_VAL_W-1:0] o_read_value,
    input logic [1:0]                           o_status,
    input logic [sal_pkg::SAL_COUNT_W-1:0]      o_count
);
    import sal_pkg::*;

    // one result per transaction, on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(start && !busy))
        else $error("result strobe does not follow transaction");

    a_full_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> ($past(i_command) == CMD_INSERT))
        else $error("full status on a non-insert transaction");

    a_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_read_value != '0)) |->
            (($past(i_command) == CMD_READ) && (o_status == ST_OK)))
        else $error("read data on a transaction that is not a good read");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (DEPTH < 16)) |-> (o_count <= SAL_COUNT_W'(DEPTH)))
        else $error("count beyond depth");

endmodule

bind sorted_array_list sal_checker #(.DEPTH(DEPTH)) u_sal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_command   (i_command),
    .o_valid     (o_valid),
    .o_read_value(o_read_value),
    .o_status    (o_status),
    .o_count     (o_count)
);
